// ===== src/amm_pkg.sv =====
`timescale 1ns / 1ps

package amm_pkg;

	// Number of channel fields that the stream payload carries.
	localparam int CH_FIELDS = 4;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 23;
	localparam int MUTE_W   = CH_FIELDS;
	localparam int ROUTE_W  = CH_FIELDS * CH_FIELDS;

	// An exact product of a Q1.23 sample and an unsigned Q4.12 gain is Q5.35.
	localparam int PROD_W = SAMPLE_W + GAIN_W;
	// Sum of all lanes with room for growth.
	localparam int ACC_W  = PROD_W + $clog2(CH_FIELDS);

	localparam int FRAC_SHIFT = 12;

	localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(2048);
	localparam logic [SAMPLE_W-1:0] SAT_MAX    = 24'h7F_FFFF;
	localparam logic [SAMPLE_W-1:0] SAT_MIN    = 24'h80_0000;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
	localparam logic [THR_W-1:0]  THR_RESET  = 23'd83886;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_GAIN_0 = 3'd0;
	localparam logic [2:0] REG_GAIN_1 = 3'd1;
	localparam logic [2:0] REG_GAIN_2 = 3'd2;
	localparam logic [2:0] REG_GAIN_3 = 3'd3;
	localparam logic [2:0] REG_MUTE   = 3'd4;
	localparam logic [2:0] REG_ROUTE  = 3'd5;
	localparam logic [2:0] REG_THRESH = 3'd6;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic        [GAIN_W-1:0]   gain_t;
	typedef logic        [THR_W-1:0]    thr_t;

	typedef struct packed {
		gain_t [CH_FIELDS-1:0] gain;
		logic  [MUTE_W-1:0]    mute;
		logic  [ROUTE_W-1:0]   route;
		thr_t                  thr;
	} cfg_t;

endpackage

// ===== src/amm_regs.sv =====
`timescale 1ns / 1ps

module amm_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output amm_pkg::cfg_t       cfg
);

	amm_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < amm_pkg::CH_FIELDS; i++) begin
				cfg_q.gain[i] <= amm_pkg::GAIN_RESET;
			end
			cfg_q.mute  <= '0;
			cfg_q.route <= '0;
			cfg_q.thr   <= amm_pkg::THR_RESET;
		end else if (wr_en) begin
			case (idx)
				amm_pkg::REG_GAIN_0: cfg_q.gain[0] <= pwdata[amm_pkg::GAIN_W-1:0];
				amm_pkg::REG_GAIN_1: cfg_q.gain[1] <= pwdata[amm_pkg::GAIN_W-1:0];
				amm_pkg::REG_GAIN_2: cfg_q.gain[2] <= pwdata[amm_pkg::GAIN_W-1:0];
				amm_pkg::REG_GAIN_3: cfg_q.gain[3] <= pwdata[amm_pkg::GAIN_W-1:0];
				amm_pkg::REG_MUTE:   cfg_q.mute    <= pwdata[amm_pkg::MUTE_W-1:0];
				amm_pkg::REG_ROUTE:  cfg_q.route   <= pwdata[amm_pkg::ROUTE_W-1:0];
				amm_pkg::REG_THRESH: cfg_q.thr     <= pwdata[amm_pkg::THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			amm_pkg::REG_GAIN_0: prdata = 32'(cfg_q.gain[0]);
			amm_pkg::REG_GAIN_1: prdata = 32'(cfg_q.gain[1]);
			amm_pkg::REG_GAIN_2: prdata = 32'(cfg_q.gain[2]);
			amm_pkg::REG_GAIN_3: prdata = 32'(cfg_q.gain[3]);
			amm_pkg::REG_MUTE:   prdata = 32'(cfg_q.mute);
			amm_pkg::REG_ROUTE:  prdata = 32'(cfg_q.route);
			amm_pkg::REG_THRESH: prdata = 32'(cfg_q.thr);
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== src/amm_lane.sv =====
`timescale 1ns / 1ps

module amm_lane (
	input  logic             clk,
	input  logic             en,
	input  amm_pkg::sample_t sample,
	input  amm_pkg::gain_t   gain,
	input  logic             muted,
	input  amm_pkg::thr_t    thr,
	output amm_pkg::prod_t   prod_s1,
	output logic             above_s1
);

	logic signed [amm_pkg::PROD_W:0]   full_prod;
	logic signed [amm_pkg::SAMPLE_W:0] sample_ext;
	logic        [amm_pkg::SAMPLE_W:0] mag;
	logic                              above;

	assign full_prod  = sample * $signed({1'b0, gain});
	assign sample_ext = {sample[amm_pkg::SAMPLE_W-1], sample};
	// The negative full-scale value maps to a magnitude of 2^23, which fits in 25 bits.
	assign mag        = sample[amm_pkg::SAMPLE_W-1] ? $unsigned(-sample_ext)
		: $unsigned(sample_ext);
	assign above      = mag > {2'b00, thr};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= muted ? '0 : amm_pkg::PROD_W'(full_prod);
			above_s1 <= above;
		end
	end

endmodule

// ===== src/amm_merge.sv =====
`timescale 1ns / 1ps

module amm_merge #(
	parameter int EFF_IN  = 4,
	parameter int EFF_OUT = 4
) (
	input  amm_pkg::prod_t              prod [amm_pkg::CH_FIELDS],
	input  logic [amm_pkg::ROUTE_W-1:0] route,
	output amm_pkg::sample_t            mix  [amm_pkg::CH_FIELDS]
);

	localparam int HI_W = amm_pkg::ACC_W - amm_pkg::FRAC_SHIFT - amm_pkg::SAMPLE_W + 1;

	logic signed [amm_pkg::ACC_W-1:0] acc     [amm_pkg::CH_FIELDS];
	logic signed [amm_pkg::ACC_W-1:0] rounded [amm_pkg::CH_FIELDS];
	logic        [HI_W-1:0]           hi      [amm_pkg::CH_FIELDS];

	always_comb begin
		for (int o = 0; o < amm_pkg::CH_FIELDS; o++) begin
			acc[o] = '0;
			for (int i = 0; i < amm_pkg::CH_FIELDS; i++) begin
				if (i < EFF_IN && route[amm_pkg::CH_FIELDS*i + o]) begin
					acc[o] = acc[o] + amm_pkg::ACC_W'(prod[i]);
				end
			end
			// Round half up, then floor by the arithmetic shift.
			rounded[o] = (acc[o] + $signed(amm_pkg::ROUND_HALF)) >>> amm_pkg::FRAC_SHIFT;
			hi[o]      = rounded[o][amm_pkg::ACC_W-amm_pkg::FRAC_SHIFT-1 -: HI_W];
			if (o >= EFF_OUT) begin
				mix[o] = '0;
			end else if (hi[o] == '0 || hi[o] == '1) begin
				mix[o] = rounded[o][amm_pkg::SAMPLE_W-1:0];
			end else if (hi[o][HI_W-1]) begin
				mix[o] = amm_pkg::SAT_MIN;
			end else begin
				mix[o] = amm_pkg::SAT_MAX;
			end
		end
	end

endmodule

// ===== src/audio_matrix_mixer_core.sv =====
// A transaction accepted on the input passes through the per-lane multiplier register
// and then the summing, rounding and saturating output register, which form a two-stage
// pipeline; it takes one transaction per cycle while m_axis_tready does not stall the output.
// Reset (arst_n low) empties the pipeline, clears the presence state and loads
// gains of 1.0, no mute, no routing and the default presence threshold.
`timescale 1ns / 1ps

module audio_matrix_mixer_core #(
	parameter int IN_CHANNELS  = 4,
	parameter int OUT_CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,

	// Input stream. tdata from bit 0 up: sample_0, sample_1, sample_2, sample_3.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,
	// tlast carries last_of_frame.
	input  logic        s_axis_tlast,

	// Output stream. tdata from bit 0 up: mix_0, mix_1, mix_2, mix_3.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,
	// tuser from bit 0 up: presence_flags (4 bits), presence_valid, zero fill.
	output logic [7:0]  m_axis_tuser,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Only four channel fields exist on the stream, so larger parameter values
	// behave as four.
	localparam int EFF_IN  = (IN_CHANNELS  < amm_pkg::CH_FIELDS) ? IN_CHANNELS
		: amm_pkg::CH_FIELDS;
	localparam int EFF_OUT = (OUT_CHANNELS < amm_pkg::CH_FIELDS) ? OUT_CHANNELS
		: amm_pkg::CH_FIELDS;
	localparam int SW      = amm_pkg::SAMPLE_W;

	amm_pkg::cfg_t cfg;

	// Stage enables. Stage 1 is the lane register, stage 2 the output register.
	// Stage 1 can still take a transaction while a finished result waits on the output, if it is empty.
	logic en1;
	logic en2;
	logic s1_valid_q;
	logic last_s1;
	logic out_valid_q;

	amm_pkg::prod_t                prod_s1 [amm_pkg::CH_FIELDS];
	logic [amm_pkg::CH_FIELDS-1:0] above_s1;
	amm_pkg::sample_t              mix_c   [amm_pkg::CH_FIELDS];
	amm_pkg::sample_t              mix_s2  [amm_pkg::CH_FIELDS];
	logic [amm_pkg::CH_FIELDS-1:0] flags_s2;
	logic                          pvalid_s2;

	// Inputs seen above the threshold in the frame so far.
	logic [amm_pkg::CH_FIELDS-1:0] seen_q;
	logic [amm_pkg::CH_FIELDS-1:0] frame_bits;

	assign en2           = !out_valid_q || m_axis_tready;
	assign en1           = !s1_valid_q || en2;
	assign s_axis_tready = en1;
	assign m_axis_tvalid = out_valid_q;

	amm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// One lane per active input: the gain multiply and the threshold compare
	// run side by side. Inactive inputs contribute nothing.
	for (genvar i = 0; i < amm_pkg::CH_FIELDS; i++) begin : g_lane
		if (i < EFF_IN) begin : g_on
			amm_lane u_lane (
				.clk      (clk),
				.en       (en1),
				.sample   ($signed(s_axis_tdata[i*SW +: SW])),
				.gain     (cfg.gain[i]),
				.muted    (cfg.mute[i]),
				.thr      (cfg.thr),
				.prod_s1  (prod_s1[i]),
				.above_s1 (above_s1[i])
			);
		end else begin : g_off
			assign prod_s1[i]  = '0;
			assign above_s1[i] = 1'b0;
		end
	end

	// The merging stage sums the routed lane products per output channel, then rounds and saturates.
	amm_merge #(
		.EFF_IN  (EFF_IN),
		.EFF_OUT (EFF_OUT)
	) u_merge (
		.prod  (prod_s1),
		.route (cfg.route),
		.mix   (mix_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (en2) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			last_s1 <= s_axis_tlast;
		end
	end

	// The current sample instant counts toward the frame it completes.
	assign frame_bits = seen_q | above_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (en2 && s1_valid_q) begin
			seen_q <= last_s1 ? '0 : frame_bits;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && s1_valid_q) begin
			mix_s2    <= mix_c;
			flags_s2  <= last_s1 ? frame_bits : '0;
			pvalid_s2 <= last_s1;
		end
	end

	for (genvar o = 0; o < amm_pkg::CH_FIELDS; o++) begin : g_out
		assign m_axis_tdata[o*SW +: SW] = mix_s2[o];
	end

	assign m_axis_tuser = {3'b000, pvalid_s2, flags_s2};

`ifndef SYNTH
	// A frame-end transaction leaving stage 1 clears the presence state.
	a_seen_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(en2 && s1_valid_q && last_s1) |=> (seen_q == '0))
		else $error("presence state not cleared after frame end");

	// Input is held off only when both pipeline stages are full and stalled.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	// A transaction in stage 1 that moves on shows up on the output.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && en2) |=> m_axis_tvalid)
		else $error("stage 1 transaction lost");
`endif

endmodule
